// ----- rtl/ca65alu_pkg.sv -----
// Package with the transaction types, function codes and status bit positions of the ALU.
package ca65alu_pkg;

    typedef enum logic [2:0] {
        FUNC_ADC = 3'd0,
        FUNC_SBC = 3'd1,
        FUNC_AND = 3'd2,
        FUNC_ORA = 3'd3,
        FUNC_EOR = 3'd4,
        FUNC_CMP = 3'd5
    } func_t;

    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam logic [15:0] MASK_WIDE   = 16'hFFFF;
    localparam logic [15:0] MASK_NARROW = 16'h00FF;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] accumulator;
        logic [15:0] operand;
        logic [15:0] compared_register;
        logic        narrow;
        logic [7:0]  status_in;
    } in_t;

    typedef struct packed {
        logic [15:0] accumulator_out;
        logic [7:0]  status_out;
    } out_t;

    typedef struct packed {
        logic [15:0] sum;
        logic        carry;
        logic        overflow;
    } add_res_t;

endpackage

// ----- rtl/ca65alu_adder.sv -----
// Binary and packed BCD adder with carry and overflow for 8-bit and 16-bit widths.
module ca65alu_adder (
    input  logic [15:0]           a,
    input  logic [15:0]           b,
    input  logic                  carry_in,
    input  logic                  decimal,
    input  logic                  sub,
    input  logic                  narrow,
    output ca65alu_pkg::add_res_t res
);
    import ca65alu_pkg::*;

    logic [16:0] bin_sum;
    logic [15:0] dec_sum;
    logic [3:0]  dec_carry;
    logic [3:0]  raw_msb;
    logic        bin_carry;
    logic        bin_sign;
    logic        dec_carry_out;
    logic        dec_sign;
    logic        a_sign;
    logic        b_sign;

    assign bin_sum = {1'b0, a} + {1'b0, b} + {16'd0, carry_in};

    always_comb begin
        logic [5:0] d;
        logic       c;
        c = carry_in;
        dec_sum = '0;
        dec_carry = '0;
        raw_msb = '0;
        for (int i = 0; i < 4; i++) begin
            d = {2'b00, a[4*i +: 4]} + {2'b00, b[4*i +: 4]} + {5'd0, c};
            raw_msb[i] = d[3];
            if (sub) begin
                c = (d > 6'd15);
                if (!c) begin
                    d = d - 6'd6;
                end
            end else begin
                if (d > 6'd9) begin
                    d = d + 6'd6;
                end
                c = (d > 6'd15);
            end
            dec_sum[4*i +: 4] = d[3:0];
            dec_carry[i] = c;
        end
    end

    assign a_sign        = narrow ? a[7] : a[15];
    assign b_sign        = narrow ? b[7] : b[15];
    assign bin_carry     = narrow ? bin_sum[8] : bin_sum[16];
    assign bin_sign      = narrow ? bin_sum[7] : bin_sum[15];
    assign dec_carry_out = narrow ? dec_carry[1] : dec_carry[3];
    assign dec_sign      = narrow ? raw_msb[1] : raw_msb[3];

    always_comb begin
        if (decimal) begin
            res.sum      = dec_sum;
            res.carry    = dec_carry_out;
            res.overflow = ~(a_sign ^ b_sign) & (a_sign ^ dec_sign);
        end else begin
            res.sum      = bin_sum[15:0];
            res.carry    = bin_carry;
            res.overflow = ~(a_sign ^ b_sign) & (a_sign ^ bin_sign);
        end
    end

endmodule

// ----- rtl/ca65alu_exec.sv -----
// Operation select, logic operations, compare and status update of the ALU.
module ca65alu_exec (
    input  ca65alu_pkg::in_t  op,
    output ca65alu_pkg::out_t res
);
    import ca65alu_pkg::*;

    logic [15:0] mask;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] b_add;
    logic [15:0] reg_m;
    logic [16:0] diff;
    logic        is_sub;
    add_res_t    add_res;
    logic [15:0] r;
    logic        r_zero;
    logic        r_neg;

    assign mask   = op.narrow ? MASK_NARROW : MASK_WIDE;
    assign a      = op.accumulator & mask;
    assign b      = op.operand & mask;
    assign reg_m  = op.compared_register & mask;
    assign is_sub = (func_t'(op.func) == FUNC_SBC);
    assign b_add  = is_sub ? (~b & mask) : b;
    assign diff   = {1'b0, reg_m} - {1'b0, b};

    ca65alu_adder u_adder (
        .a        (a),
        .b        (b_add),
        .carry_in (op.status_in[FLAG_C]),
        .decimal  (op.status_in[FLAG_D]),
        .sub      (is_sub),
        .narrow   (op.narrow),
        .res      (add_res)
    );

    always_comb begin
        case (func_t'(op.func))
            FUNC_ADC, FUNC_SBC: r = add_res.sum & mask;
            FUNC_AND:           r = a & b;
            FUNC_ORA:           r = a | b;
            FUNC_EOR:           r = a ^ b;
            FUNC_CMP:           r = diff[15:0] & mask;
            default:            r = a;
        endcase
    end

    assign r_zero = op.narrow ? (r[7:0] == 8'd0) : (r == 16'd0);
    assign r_neg  = op.narrow ? r[7] : r[15];

    always_comb begin
        res.accumulator_out = op.accumulator;
        res.status_out      = op.status_in;
        case (func_t'(op.func))
            FUNC_ADC, FUNC_SBC: begin
                res.accumulator_out        = op.narrow ? {op.accumulator[15:8], r[7:0]} : r;
                res.status_out[FLAG_C]     = add_res.carry;
                res.status_out[FLAG_V]     = add_res.overflow;
                res.status_out[FLAG_Z]     = r_zero;
                res.status_out[FLAG_N]     = r_neg;
            end
            FUNC_AND, FUNC_ORA, FUNC_EOR: begin
                res.accumulator_out        = op.narrow ? {op.accumulator[15:8], r[7:0]} : r;
                res.status_out[FLAG_Z]     = r_zero;
                res.status_out[FLAG_N]     = r_neg;
            end
            FUNC_CMP: begin
                res.status_out[FLAG_C]     = ~diff[16];
                res.status_out[FLAG_Z]     = r_zero;
                res.status_out[FLAG_N]     = r_neg;
            end
            default: begin
                res.accumulator_out = op.accumulator;
                res.status_out      = op.status_in;
            end
        endcase
    end

endmodule

// ----- rtl/cpu_accumulator_alu_65816_core.sv -----
// Top level of the accumulator ALU with input and result registers.
// Accumulator ALU of a 65816-style CPU. Each transaction carries one operation (add with
// carry, subtract with borrow, and, or, exclusive or, compare) and returns the new
// accumulator and status byte. The block has an input register and a result register
// with the whole operation computed between them, so a transaction is accepted in every
// cycle while the result side takes results. A result moves from the input register
// into the result register and can be taken at the following clock edge at the earliest.
// When a result is not taken, the result register holds it, the input register can still
// take one more transaction, and the input side stalls once both registers are full.
module cpu_accumulator_alu_65816_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ca65alu_pkg::in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output ca65alu_pkg::out_t m_payload
);
    import ca65alu_pkg::*;

    logic in_valid_reg;
    logic in_valid_next;
    in_t  in_data_reg;
    logic m_valid_reg;
    logic m_valid_next;
    out_t out_data_reg;
    out_t exec_res;
    logic advance;
    logic s_fire;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    ca65alu_exec u_exec (
        .op  (in_data_reg),
        .res (exec_res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = advance ? in_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_payload;
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= exec_res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_data_reg;

endmodule

// ----- sim/alu_result_checker.sv -----
// Checker that predicts each ALU result from the accepted operations and compares it.
`timescale 1ns / 1ps

module alu_result_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  ca65alu_pkg::in_t  s_payload,
    input  logic              m_valid,
    input  logic              m_ready,
    input  ca65alu_pkg::out_t m_payload,
    output int                mismatch_count,
    output int                outstanding
);
    import ca65alu_pkg::*;

    out_t expected_results[$];
    out_t oldest_result;

    function automatic logic [7:0] update_nz(input logic [7:0] st, input int unsigned r,
                                             input bit narrow);
        int unsigned mask;
        int unsigned sign;
        mask = narrow ? 32'h00FF : 32'hFFFF;
        sign = narrow ? 32'h0080 : 32'h8000;
        st[FLAG_Z] = (r & mask) == 0;
        st[FLAG_N] = (r & sign) != 0;
        return st;
    endfunction

    // Here b arrives already complemented when sub is set.
    function automatic out_t add_with_carry(input int unsigned a, input int unsigned b,
                                            input bit sub, input bit narrow,
                                            input logic [7:0] st);
        int unsigned mask;
        int unsigned sign;
        int unsigned digits;
        int unsigned top;
        int unsigned c;
        int unsigned d;
        int unsigned t;
        int unsigned low;
        int unsigned r;
        bit          carry;
        out_t        res;
        mask   = narrow ? 32'h00FF : 32'hFFFF;
        sign   = narrow ? 32'h0080 : 32'h8000;
        digits = narrow ? 2 : 4;
        c      = 32'(st[FLAG_C]);
        if (st[FLAG_D]) begin
            low = 0;
            top = 4 * (digits - 1);
            for (int i = 0; i < digits - 1; i++) begin
                d = ((a >> (4 * i)) & 32'hF) + ((b >> (4 * i)) & 32'hF) + c;
                if (sub) begin
                    c = 32'(d > 32'hF);
                    if (c == 0) d = d - 6;
                end else begin
                    if (d > 9) d = d + 6;
                    c = 32'(d > 32'hF);
                end
                low = low | ((d & 32'hF) << (4 * i));
            end
            t = ((a >> top) & 32'hF) + ((b >> top) & 32'hF) + c;
            r = low + (t << top);
            st[FLAG_V] = ((~(a ^ b)) & (a ^ r) & sign) != 0;
            if (sub) begin
                carry = r > mask;
                if (!carry) r = (r - (32'd6 << top)) & mask;
            end else begin
                if (t > 9) r = r + (32'd6 << top);
                carry = r > mask;
            end
        end else begin
            r = a + b + c;
            carry = r > mask;
            st[FLAG_V] = ((~(a ^ b)) & (a ^ r) & sign) != 0;
        end
        st[FLAG_C] = carry;
        r = r & mask;
        res.accumulator_out = r[15:0];
        res.status_out      = update_nz(st, r, narrow);
        return res;
    endfunction

    function automatic out_t predict_alu(input in_t op);
        int unsigned mask;
        int unsigned keep;
        int unsigned a;
        int unsigned b;
        int unsigned cmp_reg;
        int unsigned r;
        out_t        sum;
        out_t        res;
        mask = op.narrow ? 32'h00FF : 32'hFFFF;
        keep = op.narrow ? 32'hFF00 : 32'h0000;
        a    = op.accumulator & mask;
        b    = op.operand & mask;
        res.accumulator_out = op.accumulator;
        res.status_out      = op.status_in;
        case (op.func)
            FUNC_ADC, FUNC_SBC: begin
                if (op.func == FUNC_SBC) b = (~b) & mask;
                sum = add_with_carry(a, b, op.func == FUNC_SBC, op.narrow, op.status_in);
                res.accumulator_out = 16'((op.accumulator & keep) | sum.accumulator_out);
                res.status_out      = sum.status_out;
            end
            FUNC_AND, FUNC_ORA, FUNC_EOR: begin
                if (op.func == FUNC_AND) r = a & b;
                else if (op.func == FUNC_ORA) r = a | b;
                else r = a ^ b;
                res.accumulator_out = 16'((op.accumulator & keep) | r);
                res.status_out      = update_nz(op.status_in, r, op.narrow);
            end
            FUNC_CMP: begin
                cmp_reg = op.compared_register & mask;
                r = (cmp_reg - b) & mask;
                res.status_out         = op.status_in;
                res.status_out[FLAG_C] = cmp_reg >= b;
                res.status_out         = update_nz(res.status_out, r, op.narrow);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing outstanding: accumulator_out %h status_out %h",
                           m_payload.accumulator_out, m_payload.status_out);
                    mismatch_count++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (m_payload.accumulator_out !== oldest_result.accumulator_out) begin
                        $error("accumulator_out mismatch: expected %h actual %h",
                               oldest_result.accumulator_out, m_payload.accumulator_out);
                        mismatch_count++;
                    end
                    if (m_payload.status_out !== oldest_result.status_out) begin
                        $error("status_out mismatch: expected %h actual %h",
                               oldest_result.status_out, m_payload.status_out);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) expected_results.push_back(predict_alu(s_payload));
        end
        outstanding = expected_results.size();
    end

endmodule

// ----- sim/cpu_accumulator_alu_65816_core_tb.sv -----
// Top of the ALU testbench: clock, reset, directed and random operations, and the verdict.
`timescale 1ns / 1ps

module cpu_accumulator_alu_65816_core_tb;
    import ca65alu_pkg::*;

    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;
    localparam logic [7:0] ST_C = 8'h01 << FLAG_C;
    localparam logic [7:0] ST_D = 8'h01 << FLAG_D;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_OPS  = 1528;
    localparam int NUM_PHASES  = 8;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_payload;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;
    int   mismatch_count;
    int   outstanding;
    int   idle_pct;
    int   stall_pct;
    int   quiet_cycles = 0;

    cpu_accumulator_alu_65816_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    alu_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic in_t make_op(input logic [2:0] func, input logic [15:0] acc,
                                    input logic [15:0] opd, input logic [15:0] cmp_reg,
                                    input logic narrow, input logic [7:0] st);
        in_t op;
        op.func              = func;
        op.accumulator       = acc;
        op.operand           = opd;
        op.compared_register = cmp_reg;
        op.narrow            = narrow;
        op.status_in         = st;
        return op;
    endfunction

    function automatic logic [15:0] rand_word();
        logic [15:0] w;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(7))
                    0: w = 16'h0000;
                    1: w = 16'hFFFF;
                    2: w = 16'h8000;
                    3: w = 16'h7FFF;
                    4: w = 16'h0080;
                    5: w = 16'h007F;
                    6: w = 16'h00FF;
                    default: w = 16'h9999;
                endcase
            end
            1, 2, 3: begin
                w = {4'($urandom_range(9)), 4'($urandom_range(9)),
                     4'($urandom_range(9)), 4'($urandom_range(9))};
            end
            default: w = 16'($urandom);
        endcase
        return w;
    endfunction

    function automatic in_t rand_op();
        logic [2:0] func;
        if ($urandom_range(19) == 0) func = 3'($urandom_range(7, 6));
        else func = 3'($urandom_range(5));
        return make_op(func, rand_word(), rand_word(), rand_word(), 1'($urandom),
                       8'($urandom));
    endfunction

    task automatic send_op(input in_t op);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= op;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_payload    = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_op(make_op(FUNC_ADC, 16'h7FFF, 16'h0001, 16'h0000, 1'b0, 8'h00));
        send_op(make_op(FUNC_ADC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, ST_C));
        send_op(make_op(FUNC_ADC, 16'hABFF, 16'h0001, 16'h0000, 1'b1, 8'h00));
        send_op(make_op(FUNC_ADC, 16'h1299, 16'h0001, 16'h0000, 1'b1, ST_D));
        send_op(make_op(FUNC_ADC, 16'h9999, 16'h0000, 16'h0000, 1'b0, ST_D | ST_C));
        send_op(make_op(FUNC_ADC, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, ST_D | ST_C));
        send_op(make_op(FUNC_ADC, 16'h000F, 16'h00F0, 16'h0000, 1'b1, ST_D));
        send_op(make_op(FUNC_SBC, 16'h8000, 16'h0001, 16'h0000, 1'b0, ST_C));
        send_op(make_op(FUNC_SBC, 16'h5500, 16'h0001, 16'h0000, 1'b1, 8'h00));
        send_op(make_op(FUNC_SBC, 16'h0000, 16'h0001, 16'h0000, 1'b1, ST_D | ST_C));
        send_op(make_op(FUNC_SBC, 16'h0000, 16'h0001, 16'h0000, 1'b0, ST_D | ST_C));
        send_op(make_op(FUNC_SBC, 16'h5000, 16'h2500, 16'h0000, 1'b0, ST_D));
        send_op(make_op(FUNC_AND, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 8'hFF));
        send_op(make_op(FUNC_AND, 16'h12F0, 16'hFF80, 16'h0000, 1'b1, 8'h00));
        send_op(make_op(FUNC_ORA, 16'h0000, 16'h8000, 16'h0000, 1'b0, 8'h00));
        send_op(make_op(FUNC_ORA, 16'h3400, 16'h0000, 16'h0000, 1'b1, 8'h00));
        send_op(make_op(FUNC_EOR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 8'hFF));
        send_op(make_op(FUNC_EOR, 16'h00FF, 16'h007F, 16'h0000, 1'b1, 8'h00));
        send_op(make_op(FUNC_CMP, 16'hAAAA, 16'h1234, 16'h1234, 1'b0, 8'h00));
        send_op(make_op(FUNC_CMP, 16'h5555, 16'hFFFF, 16'h0000, 1'b0, 8'hFF));
        send_op(make_op(FUNC_CMP, 16'h0000, 16'h0001, 16'hFF80, 1'b1, 8'h00));
        send_op(make_op(FUNC_CMP, 16'h0000, 16'h009A, 16'h0099, 1'b1, ST_D | ST_C));
        send_op(make_op(FUNC_RSVD6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF));
        send_op(make_op(FUNC_RSVD7, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00));

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            for (int n = 0; n < RANDOM_OPS / NUM_PHASES; n++) send_op(rand_op());
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ca65alu_pkg.sv
rtl/ca65alu_adder.sv
rtl/ca65alu_exec.sv
rtl/cpu_accumulator_alu_65816_core.sv
sim/alu_result_checker.sv
sim/cpu_accumulator_alu_65816_core_tb.sv
